FILE: design/bsc_pkg.sv
// Package for the barometric compensation block: calibration, pipeline
// payload types and register addresses shared by all design files.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

  localparam int ADDR_W     = 5;
  localparam int DIV_STAGES = 64;

  localparam logic [ADDR_W-1:0] REG_TEMP_CALIB    = 5'h00;
  localparam logic [ADDR_W-1:0] REG_PRESS_CALIB_A = 5'h08;
  localparam logic [ADDR_W-1:0] REG_PRESS_CALIB_B = 5'h10;
  localparam logic [ADDR_W-1:0] REG_PRESS_CALIB_C = 5'h18;

  localparam logic [32:0] TFINE_OFFSET  = 33'd128000;
  localparam logic [20:0] PRESS_FULL    = 21'd1048576;
  localparam logic [11:0] PRESS_SCALE   = 12'd3125;
  localparam logic [31:0] TEMP_ROUND    = 32'd128;
  localparam logic [63:0] VAR1_BIAS     = 64'h0000_8000_0000_0000;

  // Calibration words unpacked from the configuration registers.
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } calib_t;

  // One divider stage: partial remainder, dividend bits shifting out while
  // quotient bits shift in, divisor magnitude and side-band results.
  typedef struct packed {
    logic [31:0] temp;
    logic        ok;
    logic        neg;
    logic [63:0] rem;
    logic [63:0] dq;
    logic [63:0] ad;
  } div_t;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic        pressure_valid;
  } res_t;

endpackage

`default_nettype wire

FILE: design/bsc_cfg.sv
// Calibration register file behind the APB-style configuration port.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_cfg import bsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output calib_t                 cal
);

  logic [47:0] temp_calib_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_c_r;
  logic        wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_a_r    <= '0;
      press_b_r    <= '0;
      press_c_r    <= '0;
    end else if (wr_en) begin
      unique case (paddr)
        REG_TEMP_CALIB:    temp_calib_r <= pwdata[47:0];
        REG_PRESS_CALIB_A: press_a_r    <= pwdata;
        REG_PRESS_CALIB_B: press_b_r    <= pwdata;
        REG_PRESS_CALIB_C: press_c_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_TEMP_CALIB:    prdata = {16'd0, temp_calib_r};
      REG_PRESS_CALIB_A: prdata = press_a_r;
      REG_PRESS_CALIB_B: prdata = press_b_r;
      REG_PRESS_CALIB_C: prdata = {48'd0, press_c_r};
      default:           prdata = '0;
    endcase
  end

  assign cal.t1 = temp_calib_r[15:0];
  assign cal.t2 = temp_calib_r[31:16];
  assign cal.t3 = temp_calib_r[47:32];
  assign cal.p1 = press_a_r[15:0];
  assign cal.p2 = press_a_r[31:16];
  assign cal.p3 = press_a_r[47:32];
  assign cal.p4 = press_a_r[63:48];
  assign cal.p5 = press_b_r[15:0];
  assign cal.p6 = press_b_r[31:16];
  assign cal.p7 = press_b_r[47:32];
  assign cal.p8 = press_b_r[63:48];
  assign cal.p9 = press_c_r;

endmodule

`default_nettype wire

FILE: design/bsc_front.sv
// Front pipeline: temperature polynomial, fine temperature and the pressure
// dividend and divisor, eleven register stages. Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_front import bsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        in_valid,
  input  wire logic [19:0] raw_temperature,
  input  wire logic [19:0] raw_pressure,
  input  calib_t           cal,
  output logic             out_valid,
  output div_t             out_data
);

  logic [10:0] vld_r;

  // Stage 1..4: 32-bit temperature path.
  logic [31:0] d1_r, d2_r, d1_nxt, d2_nxt;
  logic [19:0] ap_r [0:7];
  logic [31:0] m1_r, m2_r, m1_nxt, m2_nxt;
  logic [31:0] v1_r, q_r, v1_nxt, q_nxt, sh12, t3e;
  logic [31:0] tfine_r, tfine_nxt, q14;

  // Stage 5..11: temperature result and pressure path.
  logic [31:0]        temp_r [5:10];
  logic [31:0]        t5, temp_nxt;
  logic signed [32:0] x1_r, x1_nxt;
  logic signed [65:0] sq;
  logic signed [48:0] a5_nxt, a2_nxt;
  logic signed [48:0] a5_r [6:7];
  logic signed [48:0] a2_r [6:7];
  logic [63:0]        x1sq_r;
  logic signed [79:0] b6f, b3f;
  logic [63:0]        b6_r, b3_r;
  logic [63:0]        b3s, x2_nxt, x1n_nxt, x2_r, x1n_r;
  logic [63:0]        sum47, c_r, num0_r, num0_nxt;
  logic [79:0]        cf;
  logic [20:0]        pd;
  logic [63:0]        x1f, x1f_r, num_r;
  logic [75:0]        numf;
  logic               ok_r;

  assign d1_nxt = {15'd0, raw_temperature[19:3]} - {15'd0, cal.t1, 1'b0};
  assign d2_nxt = {16'd0, raw_temperature[19:4]} - {16'd0, cal.t1};
  assign m1_nxt = d1_r * {{16{cal.t2[15]}}, cal.t2};
  assign m2_nxt = d2_r * d2_r;
  assign v1_nxt = $signed(m1_r) >>> 11;
  assign sh12   = $signed(m2_r) >>> 12;
  assign t3e    = {{16{cal.t3[15]}}, cal.t3};
  assign q_nxt  = sh12 * t3e;
  assign q14    = $signed(q_r) >>> 14;
  assign tfine_nxt = v1_r + q14;

  assign t5       = (tfine_r << 2) + tfine_r + TEMP_ROUND;
  assign temp_nxt = $signed(t5) >>> 8;
  assign x1_nxt   = $signed({tfine_r[31], tfine_r} - TFINE_OFFSET);

  assign sq     = x1_r * x1_r;
  assign a5_nxt = x1_r * $signed(cal.p5);
  assign a2_nxt = x1_r * $signed(cal.p2);

  assign b6f = $signed(x1sq_r) * $signed(cal.p6);
  assign b3f = $signed(x1sq_r) * $signed(cal.p3);

  assign b3s     = $signed(b3_r) >>> 8;
  assign x2_nxt  = b6_r + ({{15{a5_r[7][48]}}, a5_r[7]} << 17)
                 + ({{48{cal.p4[15]}}, cal.p4} << 35);
  assign x1n_nxt = b3s + ({{15{a2_r[7][48]}}, a2_r[7]} << 12);

  assign sum47    = VAR1_BIAS + x1n_r;
  assign cf       = sum47 * cal.p1;
  assign pd       = PRESS_FULL - {1'b0, ap_r[7]};
  assign num0_nxt = ({43'd0, pd} << 31) - x2_r;

  assign x1f  = $signed(c_r) >>> 33;
  assign numf = num0_r * PRESS_SCALE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[9:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r     <= d1_nxt;
      d2_r     <= d2_nxt;
      ap_r[0]  <= raw_pressure;
      for (int i = 1; i < 8; i++) begin
        ap_r[i] <= ap_r[i-1];
      end
      m1_r     <= m1_nxt;
      m2_r     <= m2_nxt;
      v1_r     <= v1_nxt;
      q_r      <= q_nxt;
      tfine_r  <= tfine_nxt;
      temp_r[5] <= temp_nxt;
      for (int i = 6; i < 11; i++) begin
        temp_r[i] <= temp_r[i-1];
      end
      x1_r     <= x1_nxt;
      x1sq_r   <= sq[63:0];
      a5_r[6]  <= a5_nxt;
      a2_r[6]  <= a2_nxt;
      a5_r[7]  <= a5_r[6];
      a2_r[7]  <= a2_r[6];
      b6_r     <= b6f[63:0];
      b3_r     <= b3f[63:0];
      x2_r     <= x2_nxt;
      x1n_r    <= x1n_nxt;
      c_r      <= cf[63:0];
      num0_r   <= num0_nxt;
      x1f_r    <= x1f;
      num_r    <= numf[63:0];
      ok_r     <= (x1f != 64'd0);
      out_data.temp <= temp_r[10];
      out_data.ok   <= ok_r;
      out_data.neg  <= num_r[63] ^ x1f_r[63];
      out_data.rem  <= '0;
      out_data.dq   <= num_r[63] ? (64'd0 - num_r) : num_r;
      out_data.ad   <= x1f_r[63] ? (64'd0 - x1f_r) : x1f_r;
    end
  end

  assign out_valid = vld_r[10];

endmodule

`default_nettype wire

FILE: design/bsc_div.sv
// Pipelined restoring divider for the pressure quotient, one quotient bit
// per register stage. Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_div import bsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  wire logic in_valid,
  input  div_t      in_data,
  output logic      out_valid,
  output div_t      out_data
);

  div_t                  stg_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_r;

  function automatic div_t div_step(input div_t s);
    logic [64:0] t;
    logic [64:0] df;
    div_t        o;
    o  = s;
    t  = {s.rem, s.dq[63]};
    df = t - {1'b0, s.ad};
    if (!df[64]) begin
      o.rem = df[63:0];
      o.dq  = {s.dq[62:0], 1'b1};
    end else begin
      o.rem = t[63:0];
      o.dq  = {s.dq[62:0], 1'b0};
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0] <= div_step(in_data);
      for (int i = 1; i < DIV_STAGES; i++) begin
        stg_r[i] <= div_step(stg_r[i-1]);
      end
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign out_data  = stg_r[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: design/bsc_back.sv
// Back pipeline: signs the quotient and applies the second-order pressure
// correction over six register stages. Depends on bsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsc_back import bsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  wire logic in_valid,
  input  div_t      in_data,
  input  calib_t    cal,
  output logic      out_valid,
  output res_t      out_data
);

  logic [5:0]  vld_r;
  logic [31:0] temp_r [1:5];
  logic        ok_r   [1:5];
  logic [63:0] p_r    [1:4];
  logic [63:0] p_nxt;

  logic signed [63:0] ps;
  logic signed [79:0] mf, y2f;
  logic [63:0]        y2l, y2;
  logic [63:0]        ps_r, m_r;
  logic [63:0]        y2_r [2:4];
  logic [63:0]        pp0, pp0_r;
  logic [31:0]        pp1, pp2, pp1_r, pp2_r;
  logic [63:0]        prod, y1, y1_r;
  logic [63:0]        s_nxt, s_r, ss;
  logic [31:0]        pr;

  assign p_nxt = in_data.neg ? (64'd0 - in_data.dq) : in_data.dq;

  assign ps  = $signed(p_r[1]) >>> 13;
  assign mf  = $signed(cal.p9) * ps;
  assign y2f = $signed(cal.p8) * $signed(p_r[1]);
  assign y2l = y2f[63:0];
  assign y2  = $signed(y2l) >>> 19;

  // Low 64 bits of the 64 x 64 product from three 32 x 32 partials.
  assign pp0 = {32'd0, m_r[31:0]} * {32'd0, ps_r[31:0]};
  assign pp1 = m_r[31:0] * ps_r[63:32];
  assign pp2 = m_r[63:32] * ps_r[31:0];

  assign prod  = pp0_r + {pp1_r + pp2_r, 32'd0};
  assign y1    = $signed(prod) >>> 25;
  assign s_nxt = p_r[4] + y1_r + y2_r[4];
  assign ss    = $signed(s_r) >>> 8;
  assign pr    = ss[31:0] + ({{16{cal.p7[15]}}, cal.p7} << 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      temp_r[1] <= in_data.temp;
      ok_r[1]   <= in_data.ok;
      p_r[1]    <= p_nxt;
      for (int i = 2; i < 6; i++) begin
        temp_r[i] <= temp_r[i-1];
        ok_r[i]   <= ok_r[i-1];
      end
      for (int i = 2; i < 5; i++) begin
        p_r[i] <= p_r[i-1];
      end
      ps_r    <= ps;
      m_r     <= mf[63:0];
      y2_r[2] <= y2;
      y2_r[3] <= y2_r[2];
      y2_r[4] <= y2_r[3];
      pp0_r   <= pp0;
      pp1_r   <= pp1;
      pp2_r   <= pp2;
      y1_r    <= y1;
      s_r     <= s_nxt;
      out_data.temperature_centi <= temp_r[5];
      out_data.pressure_q24_8    <= ok_r[5] ? pr : 32'd0;
      out_data.pressure_valid    <= ok_r[5];
    end
  end

  assign out_valid = vld_r[5];

endmodule

`default_nettype wire

FILE: design/barometric_sensor_compensation.sv
// Barometric pressure and temperature compensation, top level.
// Usage:
//   A raw temperature and raw pressure pair is one input transaction, taken
//   when in_valid is high and in_stall is low. Each transaction yields one
//   result transaction on out_*, taken when out_valid is high and out_stall
//   is low. Results leave in the order the inputs came.
//   Calibration words are written over the cfg_ port at byte addresses 0,
//   8, 16 and 24 while no transaction is in flight; pready is tied high.
//   From input acceptance to out_valid a transaction passes eleven front
//   stages for the polynomials, 64 divider stages at one quotient bit each,
//   six correction stages and the output register. While in_stall is low,
//   one transaction is taken per cycle, the divider being fully pipelined.
//   A two-entry output (register plus skid) decouples the sides; in_stall
//   comes from the skid flag only and rises when the receiver stalls with
//   both entries full, freezing the whole pipeline without loss.
//   Synchronous reset clears all valid bits and the calibration registers.
// Depends on bsc_pkg, bsc_cfg, bsc_front, bsc_div and bsc_back.
`timescale 1ns / 1ps
`default_nettype none

module barometric_sensor_compensation import bsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [19:0]       in_raw_temperature,
  input  wire logic [19:0]       in_raw_pressure,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [31:0]            out_temperature_centi,
  output logic [31:0]            out_pressure_q24_8,
  output logic                   out_pressure_valid,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [63:0]       cfg_pwdata,
  output logic [63:0]            cfg_prdata,
  output logic                   cfg_pready
);

  calib_t cal;
  logic   adv;
  logic   f_valid, d_valid, b_valid;
  div_t   f_data, d_data;
  res_t   b_data, out_r, skid_r;
  logic   out_valid_r, skid_full_r, out_take;

  assign cfg_pready = 1'b1;
  assign adv        = !skid_full_r;
  assign in_stall   = skid_full_r;
  assign out_take   = out_valid_r && !out_stall;

  bsc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cal     (cal)
  );

  bsc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_valid),
    .raw_temperature (in_raw_temperature),
    .raw_pressure    (in_raw_pressure),
    .cal             (cal),
    .out_valid       (f_valid),
    .out_data        (f_data)
  );

  bsc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_data  (d_data)
  );

  bsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (d_valid),
    .in_data   (d_data),
    .cal       (cal),
    .out_valid (b_valid),
    .out_data  (b_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      // The pipeline is frozen; drain the skid entry first.
      if (out_take) begin
        skid_full_r <= 1'b0;
      end
    end else if (b_valid) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_full_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (b_valid) begin
      if (!out_valid_r || out_take) begin
        out_r <= b_data;
      end else begin
        skid_r <= b_data;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_r.temperature_centi;
  assign out_pressure_q24_8    = out_r.pressure_q24_8;
  assign out_pressure_valid    = out_r.pressure_valid;

endmodule

`default_nettype wire

FILE: test/barometric_sensor_compensation_tb.sv
// Testbench for the barometric compensation block: a predictor of the
// integer compensation polynomials checks every result transaction in order.
// Depends on bsc_pkg and the barometric_sensor_compensation design.
`timescale 1ns / 1ps

module barometric_sensor_compensation_tb;
  import bsc_pkg::*;

  typedef struct {
    logic [31:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic        pressure_valid;
  } comp_res_t;

  int mismatch_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Scoreboard: holds the calibration, predicts and queues results.
  class comp_scoreboard;
    logic [47:0] temp_cal;
    logic [63:0] press_a, press_b;
    logic [15:0] press_c;
    comp_res_t pending[$];

    function void set_reg(int idx, logic [63:0] v);
      case (idx)
        0: temp_cal = v[47:0];
        1: press_a = v;
        2: press_b = v;
        3: press_c = v[15:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [19:0] rt, logic [19:0] rp);
      comp_res_t r;
      logic signed [31:0] t1, t2, t3, d1, v1, d2, v2, tfine, tq;
      logic signed [63:0] x1, x2, p, num, ps, y1, y2, q;
      logic signed [63:0] c1, c2, c3, c4, c5, c6, c7, c8, c9;
      logic [63:0] an, ad, uq;
      t1 = {16'd0, temp_cal[15:0]};
      t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
      t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
      d1 = {15'd0, rt[19:3]} - (t1 <<< 1);
      v1 = (d1 * t2) >>> 11;
      d2 = {16'd0, rt[19:4]} - t1;
      tq = (d2 * d2) >>> 12;
      v2 = (tq * t3) >>> 14;
      tfine = v1 + v2;
      r.temperature_centi = (tfine * 5 + 128) >>> 8;
      c1 = {48'd0, press_a[15:0]};
      c2 = {{48{press_a[31]}}, press_a[31:16]};
      c3 = {{48{press_a[47]}}, press_a[47:32]};
      c4 = {{48{press_a[63]}}, press_a[63:48]};
      c5 = {{48{press_b[15]}}, press_b[15:0]};
      c6 = {{48{press_b[31]}}, press_b[31:16]};
      c7 = {{48{press_b[47]}}, press_b[47:32]};
      c8 = {{48{press_b[63]}}, press_b[63:48]};
      c9 = {{48{press_c[15]}}, press_c};
      x1 = {{32{tfine[31]}}, tfine} - 64'sd128000;
      x2 = x1 * x1 * c6;
      x2 = x2 + ((x1 * c5) <<< 17);
      x2 = x2 + (c4 <<< 35);
      x1 = ((x1 * x1 * c3) >>> 8) + ((x1 * c2) <<< 12);
      x1 = (((64'sd1 <<< 47) + x1) * c1) >>> 33;
      if (x1 == 0) begin
        r.pressure_q24_8 = 0;
        r.pressure_valid = 0;
      end else begin
        p = 64'sd1048576 - {44'd0, rp};
        num = ((p <<< 31) - x2) * 64'sd3125;
        // Divide on magnitudes so the most negative dividend wraps cleanly.
        an = num[63] ? -num : num;
        ad = x1[63] ? -x1 : x1;
        uq = an / ad;
        q = (num[63] != x1[63]) ? -uq : uq;
        ps = q >>> 13;
        y1 = (c9 * ps * ps) >>> 25;
        y2 = (c8 * q) >>> 19;
        p = ((q + y1 + y2) >>> 8) + (c7 <<< 4);
        r.pressure_q24_8 = p[31:0];
        r.pressure_valid = 1;
      end
      pending.push_back(r);
    endfunction

    task check_result(logic [31:0] t, logic [31:0] pq, logic pv);
      comp_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", t, 0);
        return;
      end
      e = pending.pop_front();
      if (t !== e.temperature_centi) report_mismatch("temperature", t, e.temperature_centi);
      if (pq !== e.pressure_q24_8) report_mismatch("pressure", pq, e.pressure_q24_8);
      if (pv !== e.pressure_valid) report_mismatch("pressure valid", pv, e.pressure_valid);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic [19:0] in_raw_temperature = 0, in_raw_pressure = 0;
  logic out_valid, out_stall = 0;
  logic [31:0] out_temperature_centi, out_pressure_q24_8;
  logic out_pressure_valid;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [ADDR_W-1:0] cfg_paddr = 0;
  logic [63:0] cfg_pwdata = 0, cfg_prdata;
  logic cfg_pready;

  int send_idle_pct = 0, stall_pct = 0;
  int hold_cycles = 0;
  comp_scoreboard sb;

  barometric_sensor_compensation i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  // Receiver: random stall, plus a long hold-off when hold_cycles is set.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_temperature_centi, out_pressure_q24_8, out_pressure_valid);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(int idx, logic [63:0] v);
    logic [ADDR_W-1:0] a;
    case (idx)
      0: a = REG_TEMP_CALIB;
      1: a = REG_PRESS_CALIB_A;
      2: a = REG_PRESS_CALIB_B;
      default: a = REG_PRESS_CALIB_C;
    endcase
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= a; cfg_pwdata <= v; cfg_penable <= 0;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_item(logic [19:0] rt, logic [19:0] rp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_raw_temperature <= rt; in_raw_pressure <= rp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(rt, rp);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Calibration by mode: zero, all ones, typical factory values with small random perturbation, or random.
  task automatic load_calib(int mode);
    logic [63:0] r0, r1, r2, r3;
    case (mode)
      0: begin r0 = 0; r1 = 0; r2 = 0; r3 = 0; end
      1: begin r0 = '1; r1 = '1; r2 = '1; r3 = '1; end
      2: begin
        r0 = {16'hFC18, 16'd26435, 16'd27504};
        r1 = {16'd2855, 16'hD0D0 + 16'($urandom_range(15)), 16'hD4BC, 16'd36477};
        r2 = {16'hE5F4 + 16'($urandom_range(7)), 16'hFFF9, 16'd15500, 16'd140};
        r3 = 64'd6000;
      end
      default: begin
        r0 = {$urandom, $urandom}; r1 = {$urandom, $urandom};
        r2 = {$urandom, $urandom}; r3 = {$urandom, $urandom};
      end
    endcase
    write_reg(0, r0); write_reg(1, r1); write_reg(2, r2); write_reg(3, r3);
  endtask

  task automatic random_items(int n, int mode);
    logic [19:0] rt, rp;
    for (int i = 0; i < n; i++) begin
      if (mode == 2 && $urandom_range(9) != 0) begin
        rt = 20'($urandom_range(420000, 600000));
        rp = 20'($urandom_range(250000, 480000));
      end else begin
        rt = 20'($urandom); rp = 20'($urandom);
      end
      send_item(rt, rp);
    end
  endtask

  initial begin
    sb = new();
    sb.set_reg(0, 0); sb.set_reg(1, 0); sb.set_reg(2, 0); sb.set_reg(3, 0);
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: zero calibration gives a zero divisor.
    send_item(0, 0); send_item(20'hFFFFF, 20'hFFFFF);
    drain();
    load_calib(1);
    send_item(0, 0); send_item(20'hFFFFF, 20'hFFFFF); send_item(20'h55555, 20'hAAAAA);
    drain();
    load_calib(2);
    send_item(519888, 415148); send_item(0, 0); send_item(20'hFFFFF, 20'hFFFFF);
    send_item(20'hFFFFF, 0); send_item(0, 20'hFFFFF);
    send_item(20'hAAAAA, 20'h55555); send_item(20'h55555, 20'hAAAAA);
    drain();
    // Extreme T1 and P1 to push the overflow paths.
    write_reg(0, 48'h7FFF_8000_FFFF); write_reg(1, 64'h7FFF_8000_7FFF_FFFF);
    write_reg(2, 64'h8000_7FFF_8000_7FFF); write_reg(3, 16'h8000);
    send_item(0, 0); send_item(20'hFFFFF, 20'hFFFFF); send_item(20'h80000, 20'h7FFFF);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 82; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 82; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      load_calib(2);
      if (ph == 0) hold_cycles = 300;
      random_items(230, 2);
      drain();
      load_calib(3);
      random_items(80, 3);
      drain();
    end
    if (mismatch_count == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
design/bsc_pkg.sv
design/bsc_cfg.sv
design/bsc_front.sv
design/bsc_div.sv
design/bsc_back.sv
design/barometric_sensor_compensation.sv
test/barometric_sensor_compensation_tb.sv
